// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each expects a clock and an active-low reset passed in by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AMCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define AMCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/amcf_pkg.sv =====
// ----------------------------------------------------------------------------
// amcf_pkg
// Shared types, codes and helpers of the audio module command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package amcf_pkg;

    // Host command codes
    localparam logic [2:0] OP_PLAY   = 3'd0;
    localparam logic [2:0] OP_EFFECT = 3'd1;
    localparam logic [2:0] OP_LOOP   = 3'd2;
    localparam logic [2:0] OP_VOLUME = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    // Frame bytes
    localparam logic [7:0] FR_START = 8'h7E;
    localparam logic [7:0] FR_VER   = 8'hFF;
    localparam logic [7:0] FR_LEN   = 8'h06;
    localparam logic [7:0] FR_NOFB  = 8'h00;
    localparam logic [7:0] FR_END   = 8'hEF;

    // Device command codes
    localparam logic [7:0] CMD_PLAY   = 8'h03;
    localparam logic [7:0] CMD_VOL    = 8'h06;
    localparam logic [7:0] CMD_LOOP   = 8'h08;
    localparam logic [7:0] CMD_RPTALL = 8'h11;
    localparam logic [7:0] CMD_STOP   = 8'h16;
    localparam logic [7:0] CMD_RPTTRK = 8'h19;

    localparam logic [7:0] VOL_RESET = 8'd30;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // One frame job (or a rejection) handed from front to back
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] lo;
        logic       last;
        logic       rej;
    } job_t;

    // Sixteen-bit two's complement of the checksummed bytes (the high byte is never zero)
    function automatic logic [15:0] frame_checksum(input logic [7:0] cmd,
                                                   input logic [7:0] lo);
        logic [15:0] sum;
        sum = {8'h00, FR_VER} + {8'h00, FR_LEN} + {8'h00, cmd}
            + {8'h00, FR_NOFB} + {8'h00, lo};
        return 16'h0000 - sum;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/audio_module_command_framer.sv =====
// First byte path: front job registers, job queue, back output register.
// Throughput: one byte per cycle unless out_stall holds it; a command gives one frame
// of ten bytes (four for a play after a loop), a rejected track one zero byte, an unknown op none.
// The front takes the next item as soon as its last frame job enters the queue.
// Reset: loop flag cleared, volume limit back to 30, job queue and output emptied.
// ----------------------------------------------------------------------------
// audio_module_command_framer
// Turns host commands into serial frames for an audio player module.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_module_command_framer #(
    parameter int QUEUE_DEPTH = amcf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] op,
    input  wire logic [7:0] param,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      tx_byte,
    output logic            frame_end,
    output logic            last,
    output logic            rejected,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data
);
    import amcf_pkg::*;

    job_t push_job;
    job_t head_job;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    amcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .param    (param),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    amcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    amcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .frame_end  (frame_end),
        .last       (last),
        .rejected   (rejected)
    );

endmodule

`default_nettype wire

// ===== rtl/amcf_front.sv =====
// ----------------------------------------------------------------------------
// amcf_front
// Accepts host commands, tracks looping and the volume limit, and pushes
// one frame job per cycle into the job queue while it is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module amcf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [2:0]    op,
    input  wire logic [7:0]    param,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          q_full,
    output logic               q_push,
    output amcf_pkg::job_t     q_job
);
    import amcf_pkg::*;

    localparam logic [1:0] STEP_MAIN = 2'd3;

    logic       busy_reg, busy_next;
    logic [1:0] step_reg, step_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] lo_reg, lo_next;
    logic       rej_reg, rej_next;
    logic       loop_reg, loop_next;
    logic [7:0] maxvol_reg;
    logic       final_job;
    logic       accept;
    logic       zero_track;

    // Build the job for the current step
    always_comb
    begin
        q_job.last = 1'b0;
        q_job.rej  = 1'b0;
        q_job.lo   = 8'h00;
        case (step_reg)
            2'd0: q_job.cmd = CMD_STOP;
            2'd1: q_job.cmd = CMD_RPTALL;
            2'd2:
            begin
                q_job.cmd = CMD_RPTTRK;
                q_job.lo  = 8'h01;
            end
            default:
            begin
                q_job.cmd  = cmd_reg;
                q_job.lo   = lo_reg;
                q_job.last = 1'b1;
                q_job.rej  = rej_reg;
            end
        endcase
    end

    assign q_push     = busy_reg && !q_full;
    assign final_job  = step_reg == STEP_MAIN;
    assign in_stall   = busy_reg && !(q_push && final_job);
    assign accept     = in_valid && !in_stall;
    assign zero_track = (op inside {OP_PLAY, OP_EFFECT, OP_LOOP}) && (param == 8'h00);

    // Advance the job sequence, then take a new command
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        cmd_next  = cmd_reg;
        lo_next   = lo_reg;
        rej_next  = rej_reg;
        loop_next = loop_reg;
        if (q_push)
        begin
            if (final_job)
                busy_next = 1'b0;
            else
                step_next = step_reg + 2'd1;
        end
        if (accept)
        begin
            step_next = STEP_MAIN;
            rej_next  = 1'b0;
            lo_next   = param;
            if (zero_track)
            begin
                busy_next = 1'b1;
                rej_next  = 1'b1;
                cmd_next  = 8'h00;
                lo_next   = 8'h00;
            end
            else
            begin
                case (op)
                    OP_PLAY:
                    begin
                        busy_next = 1'b1;
                        cmd_next  = CMD_PLAY;
                        if (loop_reg)
                            step_next = 2'd0;
                        loop_next = 1'b0;
                    end
                    OP_EFFECT:
                    begin
                        busy_next = 1'b1;
                        cmd_next  = CMD_PLAY;
                        loop_next = 1'b0;
                    end
                    OP_LOOP:
                    begin
                        busy_next = 1'b1;
                        cmd_next  = CMD_LOOP;
                        loop_next = 1'b1;
                    end
                    OP_VOLUME:
                    begin
                        busy_next = 1'b1;
                        cmd_next  = CMD_VOL;
                        lo_next   = (param > maxvol_reg) ? maxvol_reg : param;
                    end
                    OP_STOP:
                    begin
                        busy_next = 1'b1;
                        cmd_next  = CMD_STOP;
                        lo_next   = 8'h00;
                        loop_next = 1'b0;
                    end
                    default:
                    begin
                        // drop unknown commands
                    end
                endcase
            end
        end
    end

    // Hold control state and the volume limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= STEP_MAIN;
            loop_reg   <= 1'b0;
            maxvol_reg <= VOL_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            loop_reg <= loop_next;
            if (cfg_we)
                maxvol_reg <= cfg_data;
        end
    end

    // Hold the job payload
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        lo_reg  <= lo_next;
        rej_reg <= rej_next;
    end

endmodule

`default_nettype wire

// ===== rtl/amcf_queue.sv =====
// ----------------------------------------------------------------------------
// amcf_queue
// Short first-in first-out queue of frame jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module amcf_queue #(
    parameter int DEPTH = amcf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire amcf_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output amcf_pkg::job_t     head_job
);
    import amcf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full       = cnt_reg == CNT_FULL;
    assign head_valid = cnt_reg != '0;
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== rtl/amcf_back.sv =====
// ----------------------------------------------------------------------------
// amcf_back
// Serializes the job at the queue head into ten frame bytes (a rejection into one
// zero byte), one per cycle unless stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module amcf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire amcf_pkg::job_t head_job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         tx_byte,
    output logic               frame_end,
    output logic               last,
    output logic               rejected
);
    import amcf_pkg::*;

    localparam logic [3:0] LAST_BYTE = 4'd9;

    logic        valid_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        fend_reg, fend_next;
    logic        last_reg, last_next;
    logic        rej_reg;
    logic        advance;
    logic        emit;
    logic        final_byte;
    logic [15:0] chk;

    assign advance    = !valid_reg || !out_stall;
    assign emit       = advance && head_valid;
    assign final_byte = head_job.rej || (idx_reg == LAST_BYTE);
    assign pop        = emit && final_byte;
    assign chk        = frame_checksum(head_job.cmd, head_job.lo);

    // Select the byte for the current position
    always_comb
    begin
        case (idx_reg)
            4'd0:    byte_next = FR_START;
            4'd1:    byte_next = FR_VER;
            4'd2:    byte_next = FR_LEN;
            4'd3:    byte_next = head_job.cmd;
            4'd4:    byte_next = FR_NOFB;
            4'd5:    byte_next = 8'h00;
            4'd6:    byte_next = head_job.lo;
            4'd7:    byte_next = chk[15:8];
            4'd8:    byte_next = chk[7:0];
            default: byte_next = FR_END;
        endcase
        fend_next = idx_reg == LAST_BYTE;
        last_next = head_job.last && final_byte;
        if (head_job.rej)
        begin
            byte_next = 8'h00;
            fend_next = 1'b0;
        end
    end

    // Advance the byte position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= head_valid;
            if (emit)
                idx_reg <= final_byte ? 4'd0 : idx_reg + 4'd1;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= byte_next;
            fend_reg <= fend_next;
            last_reg <= last_next;
            rej_reg  <= head_job.rej;
        end
    end

    assign out_valid = valid_reg;
    assign tx_byte   = byte_reg;
    assign frame_end = fend_reg;
    assign last      = last_reg;
    assign rejected  = rej_reg;

endmodule

`default_nettype wire

// ===== rtl/amcf_checker.sv =====
// ----------------------------------------------------------------------------
// amcf_props
// Port-level checks of the command framer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module amcf_props (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] tx_byte,
    input wire logic       frame_end,
    input wire logic       last,
    input wire logic       rejected
);
    import amcf_pkg::*;

    // Rejection is a single zero result that ends the command
    `AMCF_ASSERT_NOW(a_reject_shape, clk, rst_n, out_valid && rejected, last && !frame_end && tx_byte == 8'h00, "rejection item malformed")

    // Every frame closes with the end byte
    `AMCF_ASSERT_NOW(a_frame_end_byte, clk, rst_n, out_valid && frame_end, tx_byte == FR_END, "frame end byte wrong")

    // A command ends on a frame boundary unless rejected
    `AMCF_ASSERT_NOW(a_last_on_end, clk, rst_n, out_valid && last && !rejected, frame_end, "last item not at frame end")

    // A stalled item holds
    `AMCF_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(last), "stalled item changed")

endmodule

bind audio_module_command_framer amcf_props u_amcf_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .frame_end (frame_end),
    .last      (last),
    .rejected  (rejected)
);

`default_nettype wire
